/* hw/rtl/vram_oam_dma_register_controller_macros.svh */
// assertion macros shared by the dma register controller
`ifndef VRAM_OAM_DMA_REGISTER_CONTROLLER_MACROS_SVH
`define VRAM_OAM_DMA_REGISTER_CONTROLLER_MACROS_SVH

// same-cycle implication, checked out of reset
`define VODRC_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vodrc: same-cycle check failed");

// next-cycle implication, checked out of reset
`define VODRC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vodrc: next-cycle check failed");

`endif

/* hw/rtl/vodrc_pkg.sv */
// types and constants of the oam / vram dma register controller
package vodrc_pkg;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_TICK  = 2'd2
   } op_type;

   localparam logic [7:0] REG_OAM_DMA  = 8'h46;
   localparam logic [7:0] REG_SRC_HI   = 8'h51;
   localparam logic [7:0] REG_SRC_LO   = 8'h52;
   localparam logic [7:0] REG_DST_HI   = 8'h53;
   localparam logic [7:0] REG_DST_LO   = 8'h54;
   localparam logic [7:0] REG_HDMA_CTL = 8'h55;

   localparam logic [15:0] OAM_BASE     = 16'hFE00;
   localparam logic [15:0] VRAM_BASE    = 16'h8000;
   localparam logic [11:0] OAM_BYTES    = 12'd160;
   localparam logic [11:0] HBLANK_BLOCK = 12'd16;
   localparam logic [15:0] HBLANK_STEP  = 16'd16;
   localparam logic [11:0] IDLE_LEN     = 12'h800;
   localparam logic [7:0]  OPEN_BUS     = 8'hFF;

   localparam int unsigned REQ_DATA_W = 16;
   localparam int unsigned RSP_DATA_W = 56;

endpackage

/* hw/rtl/vram_oam_dma_register_controller.sv */
// register side of the oam dma and vram hdma engines
//
//   channel  | ports       | direction | payload
//   ---------+-------------+-----------+------------------------------------------
//   request  | req_t*      | in        | op, register, write byte
//   response | rsp_t*      | out       | read byte, copy command (src, dst, len)
//
// one transaction per cycle sustained while the response is not stalled; a
// transaction passes the request register, then the response register. the hdma
// register file is updated when a transaction moves into the response register.
// reset clears both valid flags, the addresses and the h-blank flag; mode and length go idle.
// a stalled response holds; one more request waits in the request register.

`include "vram_oam_dma_register_controller_macros.svh"

module vram_oam_dma_register_controller (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [vodrc_pkg::REQ_DATA_W-1:0] req_tdata,  // reg_req [7:0], data [15:8]
   input  logic [1:0]  req_tuser,  // op [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [vodrc_pkg::RSP_DATA_W-1:0] rsp_tdata,  // read_data [7:0], copy_src [23:8],
                                   // copy_dst [39:24], copy_len [51:40], zeros
   output logic        rsp_tuser   // copy_valid [0]
);

   // request register
   logic        req_valid_ff, req_valid_in;
   logic [1:0]  op_ff;
   logic [7:0]  reg_ff;
   logic [7:0]  data_ff;

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  read_data_ff, read_data_in;
   logic        copy_valid_ff, copy_valid_in;
   logic [15:0] copy_src_ff, copy_src_in;
   logic [15:0] copy_dst_ff, copy_dst_in;
   logic [11:0] copy_len_ff, copy_len_in;

   // hdma register file
   logic [15:0] src_addr_ff, src_addr_in;
   logic [15:0] dst_offset_ff, dst_offset_in;
   logic        mode_bit_ff, mode_bit_in;
   logic [11:0] remaining_len_ff, remaining_len_in;
   logic        hblank_active_ff, hblank_active_in;

   logic        rsp_free;
   logic        advance;
   logic [11:0] ctl_len;
   logic [7:0]  ctl_read;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = req_valid_ff && rsp_free;
   assign req_tready = !req_valid_ff || rsp_free;

   assign req_valid_in = (req_tvalid && req_tready) || (req_valid_ff && !rsp_free);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   // length written to the control register, in bytes
   assign ctl_len  = {8'({1'b0, data_ff[6:0]} + 8'd1), 4'b0000};
   assign ctl_read = {mode_bit_ff, 7'd0} | (remaining_len_ff[11:4] - 8'd1);

   always_comb begin
      read_data_in     = vodrc_pkg::OPEN_BUS;
      copy_valid_in    = 1'b0;
      copy_src_in      = '0;
      copy_dst_in      = '0;
      copy_len_in      = '0;
      src_addr_in      = src_addr_ff;
      dst_offset_in    = dst_offset_ff;
      mode_bit_in      = mode_bit_ff;
      remaining_len_in = remaining_len_ff;
      hblank_active_in = hblank_active_ff;
      unique case (op_ff)
         vodrc_pkg::OP_WRITE: begin
            unique case (reg_ff)
               vodrc_pkg::REG_OAM_DMA: begin
                  copy_valid_in = 1'b1;
                  copy_src_in   = {data_ff, 8'h00};
                  copy_dst_in   = vodrc_pkg::OAM_BASE;
                  copy_len_in   = vodrc_pkg::OAM_BYTES;
               end
               vodrc_pkg::REG_SRC_HI: src_addr_in = {data_ff, src_addr_ff[7:4], 4'b0000};
               vodrc_pkg::REG_SRC_LO: src_addr_in = {src_addr_ff[15:8], data_ff[7:4], 4'b0000};
               vodrc_pkg::REG_DST_HI: dst_offset_in = {3'b000, data_ff[4:0], dst_offset_ff[7:0]};
               vodrc_pkg::REG_DST_LO: begin
                  dst_offset_in = {3'b000, dst_offset_ff[12:8], data_ff[7:4], 4'b0000};
               end
               vodrc_pkg::REG_HDMA_CTL: begin
                  priority if (hblank_active_ff && !data_ff[7]) begin
                     // stop an h-blank transfer in progress
                     hblank_active_in = 1'b0;
                     mode_bit_in      = 1'b0;
                     remaining_len_in = ctl_len;
                  end else if (!data_ff[7]) begin
                     // general copy, done at once
                     copy_valid_in    = 1'b1;
                     copy_src_in      = src_addr_ff;
                     copy_dst_in      = vodrc_pkg::VRAM_BASE + dst_offset_ff;
                     copy_len_in      = ctl_len;
                     mode_bit_in      = 1'b1;
                     remaining_len_in = vodrc_pkg::IDLE_LEN;
                  end else begin
                     hblank_active_in = 1'b1;
                     mode_bit_in      = 1'b0;
                     remaining_len_in = ctl_len;
                  end
               end
               default: ;
            endcase
         end
         vodrc_pkg::OP_READ: begin
            unique case (reg_ff)
               vodrc_pkg::REG_SRC_HI:   read_data_in = src_addr_ff[7:0];
               vodrc_pkg::REG_SRC_LO:   read_data_in = src_addr_ff[15:8];
               vodrc_pkg::REG_DST_HI:   read_data_in = dst_offset_ff[7:0];
               vodrc_pkg::REG_DST_LO:   read_data_in = dst_offset_ff[15:8];
               vodrc_pkg::REG_HDMA_CTL: read_data_in = ctl_read;
               default:                 read_data_in = vodrc_pkg::OPEN_BUS;
            endcase
         end
         vodrc_pkg::OP_TICK: begin
            if (hblank_active_ff) begin
               copy_valid_in = 1'b1;
               copy_src_in   = src_addr_ff;
               copy_dst_in   = vodrc_pkg::VRAM_BASE + dst_offset_ff;
               copy_len_in   = vodrc_pkg::HBLANK_BLOCK;
               src_addr_in   = src_addr_ff + vodrc_pkg::HBLANK_STEP;
               dst_offset_in = dst_offset_ff + vodrc_pkg::HBLANK_STEP;
               if (remaining_len_ff <= vodrc_pkg::HBLANK_BLOCK) begin
                  // last block of the transfer
                  mode_bit_in      = 1'b1;
                  remaining_len_in = vodrc_pkg::IDLE_LEN;
                  hblank_active_in = 1'b0;
               end else begin
                  remaining_len_in = remaining_len_ff - vodrc_pkg::HBLANK_BLOCK;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         src_addr_ff      <= '0;
         dst_offset_ff    <= '0;
         mode_bit_ff      <= 1'b1;
         remaining_len_ff <= vodrc_pkg::IDLE_LEN;
         hblank_active_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            src_addr_ff      <= src_addr_in;
            dst_offset_ff    <= dst_offset_in;
            mode_bit_ff      <= mode_bit_in;
            remaining_len_ff <= remaining_len_in;
            hblank_active_ff <= hblank_active_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         op_ff   <= req_tuser;
         reg_ff  <= req_tdata[7:0];
         data_ff <= req_tdata[15:8];
      end
      if (advance) begin
         read_data_ff  <= read_data_in;
         copy_valid_ff <= copy_valid_in;
         copy_src_ff   <= copy_src_in;
         copy_dst_ff   <= copy_dst_in;
         copy_len_ff   <= copy_len_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = copy_valid_ff;
   assign rsp_tdata  = {4'b0000, copy_len_ff, copy_dst_ff, copy_src_ff, read_data_ff};

   `VODRC_ASSERT_NOW(a_active_clears_mode, clock, reset, hblank_active_ff, !mode_bit_ff)
   `VODRC_ASSERT_NOW(a_len_whole_blocks, clock, reset, 1'b1,
                     remaining_len_ff != 12'd0 && remaining_len_ff[3:0] == 4'd0)
   `VODRC_ASSERT_NOW(a_no_copy_zero_fields, clock, reset, rsp_valid_ff && !copy_valid_ff,
                     copy_src_ff == 16'd0 && copy_dst_ff == 16'd0 && copy_len_ff == 12'd0)
   `VODRC_ASSERT_NEXT(a_last_block_ends, clock, reset,
                      advance && op_ff == vodrc_pkg::OP_TICK && hblank_active_ff &&
                      remaining_len_ff <= vodrc_pkg::HBLANK_BLOCK,
                      !hblank_active_ff && mode_bit_ff && copy_valid_ff)

endmodule

/* dv/testbench.sv */
// self-checking testbench for the oam / vram dma register controller
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0]  OP_UNUSED      = 2'd3;
   localparam logic [7:0]  REG_UNUSED_LO  = 8'h00;
   localparam logic [7:0]  REG_UNUSED_HI  = 8'hFF;
   localparam int unsigned RANDOM_ITEMS   = 375;
   localparam int unsigned QUIET_LIMIT    = 1000;
   localparam int unsigned HOLD_CYCLES    = 80;
   localparam int unsigned HOLD_AFTER     = 150;
   localparam int unsigned DRAIN_CYCLES   = 8;

   typedef struct packed {
      logic [7:0]  rd;
      logic        copy;
      logic [15:0] src;
      logic [15:0] dst;
      logic [11:0] len;
   } dma_rsp_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  addr;
      logic [7:0]  wbyte;
      logic        known;
      dma_rsp_type known_rsp;
   } dma_item_type;

   localparam dma_rsp_type NO_COPY = {vodrc_pkg::OPEN_BUS, 1'b0, 16'h0000, 16'h0000, 12'h000};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic        rsp_tuser;

   // hdma register file as the testbench sees it
   logic [15:0] hdma_src = '0;
   logic [15:0] hdma_dst = '0;
   logic        hdma_mode = 1'b1;
   logic [11:0] hdma_len = vodrc_pkg::IDLE_LEN;
   logic        hdma_armed = 1'b0;

   dma_item_type stim_q[$];
   dma_rsp_type  pending_rsp[$];
   int unsigned accepted_n = 0;
   int unsigned rsp_count = 0;
   int unsigned mismatches = 0;
   int unsigned quiet_cycles = 0;

   vram_oam_dma_register_controller DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void add_item(logic [1:0] op, logic [7:0] addr, logic [7:0] wbyte,
                                    logic known, dma_rsp_type known_rsp);
      dma_item_type it;
      it = {op, addr, wbyte, known, known_rsp};
      stim_q.insert(stim_q.size(), it);
   endfunction

   // one transaction against the hdma register file, updates the file
   function automatic dma_rsp_type predict_dma(logic [1:0] op, logic [7:0] addr,
                                               logic [7:0] wbyte);
      dma_rsp_type p;
      p = NO_COPY;
      case (op)
         vodrc_pkg::OP_WRITE: begin
            case (addr)
               vodrc_pkg::REG_OAM_DMA: begin
                  p.copy = 1'b1;
                  p.src  = {wbyte, 8'h00};
                  p.dst  = vodrc_pkg::OAM_BASE;
                  p.len  = vodrc_pkg::OAM_BYTES;
               end
               vodrc_pkg::REG_SRC_HI: hdma_src = {wbyte, hdma_src[7:4], 4'h0};
               vodrc_pkg::REG_SRC_LO: hdma_src = {hdma_src[15:8], wbyte[7:4], 4'h0};
               vodrc_pkg::REG_DST_HI: hdma_dst = {3'b000, wbyte[4:0], hdma_dst[7:0]};
               vodrc_pkg::REG_DST_LO: hdma_dst = {3'b000, hdma_dst[12:8], wbyte[7:4], 4'h0};
               vodrc_pkg::REG_HDMA_CTL: begin
                  hdma_mode = wbyte[7];
                  hdma_len  = ({5'd0, wbyte[6:0]} + 12'd1) << 4;
                  if (hdma_armed && !hdma_mode) begin
                     // cancel of a running h-blank transfer
                     hdma_armed = 1'b0;
                  end else if (!hdma_mode) begin
                     p.copy    = 1'b1;
                     p.src     = hdma_src;
                     p.dst     = vodrc_pkg::VRAM_BASE + hdma_dst;
                     p.len     = hdma_len;
                     hdma_mode = 1'b1;
                     hdma_len  = vodrc_pkg::IDLE_LEN;
                  end else begin
                     hdma_armed = 1'b1;
                     hdma_mode  = 1'b0;
                  end
               end
               default: ;
            endcase
         end
         vodrc_pkg::OP_READ: begin
            case (addr)
               vodrc_pkg::REG_SRC_HI:   p.rd = hdma_src[7:0];
               vodrc_pkg::REG_SRC_LO:   p.rd = hdma_src[15:8];
               vodrc_pkg::REG_DST_HI:   p.rd = hdma_dst[7:0];
               vodrc_pkg::REG_DST_LO:   p.rd = hdma_dst[15:8];
               vodrc_pkg::REG_HDMA_CTL: p.rd = {hdma_mode, 7'b0} | (hdma_len[11:4] - 8'd1);
               default: ;
            endcase
         end
         vodrc_pkg::OP_TICK: begin
            if (hdma_armed) begin
               p.copy   = 1'b1;
               p.src    = hdma_src;
               p.dst    = vodrc_pkg::VRAM_BASE + hdma_dst;
               p.len    = vodrc_pkg::HBLANK_BLOCK;
               hdma_dst = hdma_dst + vodrc_pkg::HBLANK_STEP;
               hdma_src = hdma_src + vodrc_pkg::HBLANK_STEP;
               if (hdma_len <= vodrc_pkg::HBLANK_BLOCK) begin
                  hdma_mode  = 1'b1;
                  hdma_len   = vodrc_pkg::IDLE_LEN;
                  hdma_armed = 1'b0;
               end else begin
                  hdma_len = hdma_len - vodrc_pkg::HBLANK_BLOCK;
               end
            end
         end
         default: ;
      endcase
      return p;
   endfunction

   task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
      end
   endtask

   // predict every accepted request transaction
   always @(posedge clock) begin : req_monitor
      dma_rsp_type model_rsp;
      if (!reset && req_tvalid && req_tready) begin
         model_rsp = predict_dma(req_tuser, req_tdata[7:0], req_tdata[15:8]);
         if (stim_q[accepted_n].known)
            model_rsp = stim_q[accepted_n].known_rsp;
         pending_rsp.insert(pending_rsp.size(), model_rsp);
         accepted_n++;
      end
   end

   always @(posedge clock) begin : rsp_monitor
      dma_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_count++;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected response, expected none, got data 0x%0h copy %0b",
                     $time, rsp_tdata, rsp_tuser);
         end else begin
            want = pending_rsp.pop_front();
            check_field("read_data", {8'h00, want.rd}, {8'h00, rsp_tdata[7:0]});
            check_field("copy_valid", {15'd0, want.copy}, {15'd0, rsp_tuser});
            check_field("copy_src", want.src, rsp_tdata[23:8]);
            check_field("copy_dst", want.dst, rsp_tdata[39:24]);
            check_field("copy_len", {4'h0, want.len}, {4'h0, rsp_tdata[51:40]});
            check_field("pad", 16'h0000, {12'h000, rsp_tdata[55:52]});
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // receiver: stall pattern redrawn once each 32-bit mask is used up, one long hold-off
   initial begin : rsp_side
      int unsigned phase;
      int unsigned style;
      logic [31:0] stall_mask;
      bit held;
      phase = 0;
      held = 0;
      stall_mask = '1;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_tready = 1'b0;
         end else if (!held && rsp_count >= HOLD_AFTER) begin
            held = 1;
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            if (phase == 0) begin
               style = $urandom_range(0, 3);
               case (style)
                  0: stall_mask = '1;
                  1: stall_mask = $urandom();
                  2: stall_mask = $urandom() | $urandom();
                  default: stall_mask = $urandom() & $urandom();
               endcase
            end
            rsp_tready = stall_mask[phase];
            phase = (phase + 1) % 32;
         end
      end
   end

   initial begin : req_side
      int unsigned idx, burst, gap, k, n, blocks, kind, base_n;
      logic [1:0] op_v;
      logic [7:0] addr_v, byte_v;

      // directed table: reset values, extremes, every register, hdma corner cases
      add_item(vodrc_pkg::OP_READ,  vodrc_pkg::REG_HDMA_CTL, 8'h00, 1'b1, NO_COPY);
      add_item(vodrc_pkg::OP_READ,  vodrc_pkg::REG_SRC_HI,   8'h00, 1'b1,
               {8'h00, 1'b0, 32'h0, 12'h000});
      add_item(vodrc_pkg::OP_TICK,  vodrc_pkg::REG_HDMA_CTL, 8'hFF, 1'b1, NO_COPY);
      add_item(OP_UNUSED,           vodrc_pkg::REG_HDMA_CTL, 8'hFF, 1'b1, NO_COPY);
      add_item(vodrc_pkg::OP_WRITE, REG_UNUSED_LO,           8'hFF, 1'b1, NO_COPY);
      add_item(vodrc_pkg::OP_READ,  REG_UNUSED_HI,           8'h00, 1'b1, NO_COPY);
      add_item(vodrc_pkg::OP_WRITE, vodrc_pkg::REG_OAM_DMA,  8'hFF, 1'b1,
               {vodrc_pkg::OPEN_BUS, 1'b1, 16'hFF00, vodrc_pkg::OAM_BASE,
                vodrc_pkg::OAM_BYTES});
      add_item(vodrc_pkg::OP_WRITE, vodrc_pkg::REG_OAM_DMA,  8'h00, 1'b1,
               {vodrc_pkg::OPEN_BUS, 1'b1, 16'h0000, vodrc_pkg::OAM_BASE,
                vodrc_pkg::OAM_BYTES});
      add_item(vodrc_pkg::OP_WRITE, vodrc_pkg::REG_SRC_HI,   8'hFF, 1'b1, NO_COPY);
      add_item(vodrc_pkg::OP_WRITE, vodrc_pkg::REG_SRC_LO,   8'hFF, 1'b1, NO_COPY);
      add_item(vodrc_pkg::OP_WRITE, vodrc_pkg::REG_DST_HI,   8'hFF, 1'b1, NO_COPY);
      add_item(vodrc_pkg::OP_WRITE, vodrc_pkg::REG_DST_LO,   8'hFF, 1'b1, NO_COPY);
      add_item(vodrc_pkg::OP_READ,  vodrc_pkg::REG_SRC_HI,   8'h00, 1'b0, NO_COPY);
      add_item(vodrc_pkg::OP_READ,  vodrc_pkg::REG_DST_LO,   8'h00, 1'b0, NO_COPY);
      // general copies, longest and shortest
      add_item(vodrc_pkg::OP_WRITE, vodrc_pkg::REG_HDMA_CTL, 8'h7F, 1'b0, NO_COPY);
      add_item(vodrc_pkg::OP_WRITE, vodrc_pkg::REG_HDMA_CTL, 8'h00, 1'b0, NO_COPY);
      add_item(vodrc_pkg::OP_READ,  vodrc_pkg::REG_HDMA_CTL, 8'h00, 1'b1, NO_COPY);
      // short h-blank transfer, ticked until it runs out
      add_item(vodrc_pkg::OP_WRITE, vodrc_pkg::REG_HDMA_CTL, 8'h81, 1'b0, NO_COPY);
      add_item(vodrc_pkg::OP_TICK,  REG_UNUSED_LO,           8'h00, 1'b0, NO_COPY);
      add_item(vodrc_pkg::OP_TICK,  REG_UNUSED_LO,           8'h00, 1'b0, NO_COPY);
      // arm at full length, re-arm while running, tick, then cancel
      add_item(vodrc_pkg::OP_WRITE, vodrc_pkg::REG_HDMA_CTL, 8'hFF, 1'b0, NO_COPY);
      add_item(vodrc_pkg::OP_WRITE, vodrc_pkg::REG_HDMA_CTL, 8'h85, 1'b0, NO_COPY);
      add_item(vodrc_pkg::OP_TICK,  REG_UNUSED_LO,           8'h00, 1'b0, NO_COPY);
      add_item(vodrc_pkg::OP_WRITE, vodrc_pkg::REG_HDMA_CTL, 8'h00, 1'b0, NO_COPY);
      add_item(vodrc_pkg::OP_READ,  vodrc_pkg::REG_HDMA_CTL, 8'h00, 1'b0, NO_COPY);
      add_item(vodrc_pkg::OP_TICK,  REG_UNUSED_LO,           8'h00, 1'b0, NO_COPY);

      base_n = stim_q.size();
      while (stim_q.size() - base_n < RANDOM_ITEMS) begin
         kind = $urandom_range(0, 9);
         if (kind <= 1) begin
            // noise: any op, any register, any byte
            op_v = 2'($urandom_range(0, 3));
            k = $urandom_range(0, 5);
            if ($urandom_range(0, 1) == 0)
               addr_v = 8'($urandom_range(0, 255));
            else
               addr_v = (k == 0) ? vodrc_pkg::REG_OAM_DMA
                                 : vodrc_pkg::REG_SRC_HI + 8'(k - 1);
            add_item(op_v, addr_v, 8'($urandom_range(0, 255)), 1'b0, NO_COPY);
         end else if (kind == 2) begin
            add_item(vodrc_pkg::OP_WRITE, vodrc_pkg::REG_OAM_DMA,
                     8'($urandom_range(0, 255)), 1'b0, NO_COPY);
         end else if (kind <= 7) begin
            // well-formed hdma setup followed by a general or h-blank start
            for (k = 0; k < 4; k++)
               if ($urandom_range(0, 2) != 0)
                  add_item(vodrc_pkg::OP_WRITE, vodrc_pkg::REG_SRC_HI + 8'(k),
                           8'($urandom_range(0, 255)), 1'b0, NO_COPY);
            blocks = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127)
                                                 : $urandom_range(0, 4);
            if (kind <= 5) begin
               add_item(vodrc_pkg::OP_WRITE, vodrc_pkg::REG_HDMA_CTL, {1'b1, 7'(blocks)},
                        1'b0, NO_COPY);
               n = ((blocks < 12) ? blocks + 1 : 12) + $urandom_range(0, 2);
               for (k = 0; k < n; k++) begin
                  if ($urandom_range(0, 3) == 0)
                     add_item(vodrc_pkg::OP_READ,
                              vodrc_pkg::REG_SRC_HI + 8'($urandom_range(0, 4)),
                              8'($urandom_range(0, 255)), 1'b0, NO_COPY);
                  if ($urandom_range(0, 15) == 0)
                     add_item(vodrc_pkg::OP_WRITE, vodrc_pkg::REG_HDMA_CTL,
                              8'($urandom_range(0, 255)), 1'b0, NO_COPY);
                  add_item(vodrc_pkg::OP_TICK, 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)), 1'b0, NO_COPY);
               end
            end else begin
               add_item(vodrc_pkg::OP_WRITE, vodrc_pkg::REG_HDMA_CTL, {1'b0, 7'(blocks)},
                        1'b0, NO_COPY);
            end
            if ($urandom_range(0, 1) == 0)
               add_item(vodrc_pkg::OP_READ, vodrc_pkg::REG_HDMA_CTL, 8'h00, 1'b0, NO_COPY);
         end else begin
            add_item(vodrc_pkg::OP_READ, vodrc_pkg::REG_SRC_HI + 8'($urandom_range(0, 4)),
                     8'($urandom_range(0, 255)), 1'b0, NO_COPY);
         end
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // sender: bursts of back-to-back transactions with random gaps
      idx = 0;
      while (idx < stim_q.size()) begin
         burst = $urandom_range(1, 24);
         while (burst != 0 && idx < stim_q.size()) begin
            @(negedge clock);
            req_tuser  = stim_q[idx].op;
            req_tdata  = {stim_q[idx].wbyte, stim_q[idx].addr};
            req_tvalid = 1'b1;
            @(posedge clock);
            while (!req_tready) @(posedge clock);
            idx++;
            burst--;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            @(negedge clock);
            req_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      @(negedge clock);
      req_tvalid = 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
